### hdl/irn_pkg.sv
package irn_pkg;

	// frame store geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

	// payload and register widths
	localparam int PIX_W   = 24;
	localparam int COORD_W = 8;
	localparam int DIM_W   = 9;
	localparam int TRIG_W  = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	// datapath widths: centred offset, product, sum, source coordinate
	localparam int DIFF_W = COORD_W + 2;
	localparam int PROD_W = DIFF_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int Q_FRAC = 14;
	localparam int SHIFT  = Q_FRAC + 1;
	localparam int SRC_W  = SUM_W - SHIFT;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// result queue in the back part
	localparam int OUT_DEPTH = 4;
	localparam int OPTR_W    = $clog2(OUT_DEPTH);
	localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_COS    = 2'd0,
		REG_SIN    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	// active configuration, sizes already clamped to the store
	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
		logic [DIM_W-1:0]         w;
		logic [DIM_W-1:0]         h;
	} cfg_t;

	// one classified word for the back part
	typedef struct packed {
		logic              is_read;
		logic              in_src;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pixel;
	} entry_t;

endpackage

### hdl/irn_front.sv
module irn_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  irn_pkg::cfg_t                  cfg,
	input  logic                           push,
	output logic                           full,
	input  logic                           command,
	input  logic [irn_pkg::COORD_W-1:0]    col,
	input  logic [irn_pkg::COORD_W-1:0]    row,
	input  logic [irn_pkg::PIX_W-1:0]      pixel_in,
	output logic                           q_push,
	input  logic                           q_full,
	output irn_pkg::entry_t                q_data
);

	logic adv;
	logic take;

	// stage 1: centred offsets
	logic                                v_s1;
	logic                                cmd_s1;
	logic                                wr_ok_s1;
	logic [irn_pkg::COORD_W-1:0]         col_s1;
	logic [irn_pkg::COORD_W-1:0]         row_s1;
	logic [irn_pkg::PIX_W-1:0]           pix_s1;
	logic signed [irn_pkg::DIFF_W-1:0]   dx_s1;
	logic signed [irn_pkg::DIFF_W-1:0]   dy_s1;

	// stage 2: products
	logic                                v_s2;
	logic                                cmd_s2;
	logic                                wr_ok_s2;
	logic [irn_pkg::COORD_W-1:0]         col_s2;
	logic [irn_pkg::COORD_W-1:0]         row_s2;
	logic [irn_pkg::PIX_W-1:0]           pix_s2;
	logic signed [irn_pkg::PROD_W-1:0]   pxc_s2;
	logic signed [irn_pkg::PROD_W-1:0]   pys_s2;
	logic signed [irn_pkg::PROD_W-1:0]   pyc_s2;
	logic signed [irn_pkg::PROD_W-1:0]   pxs_s2;

	// stage 3: source coordinate and class
	logic                                v_s3;
	logic                                keep_s3;
	logic                                cmd_s3;
	logic                                inside_s3;
	logic [irn_pkg::XW-1:0]              x_s3;
	logic [irn_pkg::YW-1:0]              y_s3;
	logic [irn_pkg::PIX_W-1:0]           pix_s3;

	// stage 4: store address
	logic                                v_s4;
	irn_pkg::entry_t                     ent_s4;

	logic signed [irn_pkg::SUM_W-1:0]    nx;
	logic signed [irn_pkg::SUM_W-1:0]    ny;
	logic [irn_pkg::SRC_W-1:0]           xs;
	logic [irn_pkg::SRC_W-1:0]           ys;
	logic                                in_img;
	logic                                wr_ok;

	// stall the whole pipe only when a finished word cannot enter the queue
	assign adv    = !(v_s4 && q_full);
	assign full   = !adv;
	assign take   = push && adv;
	assign q_push = v_s4 && !q_full;
	assign q_data = ent_s4;

	// drop writes that fall beyond the store
	assign wr_ok = (32'(col) < irn_pkg::MAX_WIDTH) && (32'(row) < irn_pkg::MAX_HEIGHT);

	// rotate back to the source: exact sums, floor by shift
	assign nx = irn_pkg::SUM_W'(pxc_s2) + irn_pkg::SUM_W'(pys_s2)
		+ irn_pkg::SUM_W'({cfg.w, irn_pkg::Q_FRAC'(0)});
	assign ny = irn_pkg::SUM_W'(pyc_s2) - irn_pkg::SUM_W'(pxs_s2)
		+ irn_pkg::SUM_W'({cfg.h, irn_pkg::Q_FRAC'(0)});
	assign xs = nx[irn_pkg::SUM_W-1:irn_pkg::SHIFT];
	assign ys = ny[irn_pkg::SUM_W-1:irn_pkg::SHIFT];
	assign in_img = !nx[irn_pkg::SUM_W-1] && !ny[irn_pkg::SUM_W-1]
		&& (xs < irn_pkg::SRC_W'(cfg.w)) && (ys < irn_pkg::SRC_W'(cfg.h));

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && keep_s3;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= command;
			wr_ok_s1 <= wr_ok;
			col_s1   <= col;
			row_s1   <= row;
			pix_s1   <= pixel_in;
			dx_s1    <= $signed({1'b0, col, 1'b0}) - $signed({1'b0, cfg.w});
			dy_s1    <= $signed({1'b0, row, 1'b0}) - $signed({1'b0, cfg.h});

			cmd_s2   <= cmd_s1;
			wr_ok_s2 <= wr_ok_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			pix_s2   <= pix_s1;
			pxc_s2   <= dx_s1 * cfg.cos_v;
			pys_s2   <= dy_s1 * cfg.sin_v;
			pyc_s2   <= dy_s1 * cfg.cos_v;
			pxs_s2   <= dx_s1 * cfg.sin_v;

			cmd_s3   <= cmd_s2;
			pix_s3   <= pix_s2;
			if (cmd_s2 == irn_pkg::CMD_READ) begin
				keep_s3   <= 1'b1;
				inside_s3 <= in_img;
				x_s3      <= nx[irn_pkg::SHIFT +: irn_pkg::XW];
				y_s3      <= ny[irn_pkg::SHIFT +: irn_pkg::YW];
			end else begin
				keep_s3   <= wr_ok_s2;
				inside_s3 <= 1'b0;
				x_s3      <= irn_pkg::XW'(col_s2);
				y_s3      <= irn_pkg::YW'(row_s2);
			end

			ent_s4.is_read <= (cmd_s3 == irn_pkg::CMD_READ);
			ent_s4.in_src  <= inside_s3;
			ent_s4.addr    <= irn_pkg::ADDR_W'(y_s3) * irn_pkg::ADDR_W'(irn_pkg::MAX_WIDTH)
				+ irn_pkg::ADDR_W'(x_s3);
			ent_s4.pixel   <= pix_s3;
		end
	end

endmodule

### hdl/irn_queue.sv
module irn_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  irn_pkg::entry_t wdata,
	input  logic            pop,
	output logic            empty,
	output irn_pkg::entry_t rdata
);

	irn_pkg::entry_t               slot_q [irn_pkg::QDEPTH];
	logic [irn_pkg::QPTR_W-1:0]    wptr_q;
	logic [irn_pkg::QPTR_W-1:0]    rptr_q;
	logic [irn_pkg::QCNT_W-1:0]    cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (cnt_q == irn_pkg::QCNT_W'(irn_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rptr_q];

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// store words
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wptr_q] <= wdata;
	end

endmodule

### hdl/irn_back.sv
module irn_back (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       q_pop,
	input  logic                       q_empty,
	input  irn_pkg::entry_t            q_data,
	output logic                       empty,
	input  logic                       pop,
	output logic [irn_pkg::PIX_W-1:0]  pixel_out,
	output logic                       inside_res
);

	logic [irn_pkg::PIX_W-1:0] mem [irn_pkg::MAX_WIDTH * irn_pkg::MAX_HEIGHT];
	logic [irn_pkg::PIX_W-1:0] rdata_q;

	logic                      v_s1;
	logic                      inside_s1;

	logic [irn_pkg::PIX_W-1:0] opix_q [irn_pkg::OUT_DEPTH];
	logic                      oin_q  [irn_pkg::OUT_DEPTH];
	logic [irn_pkg::OPTR_W-1:0] owptr_q;
	logic [irn_pkg::OPTR_W-1:0] orptr_q;
	logic [irn_pkg::OCNT_W-1:0] ocnt_q;

	logic                      do_pop;
	logic                      we;
	logic                      re;
	logic [irn_pkg::PIX_W-1:0] res_pix;

	// take a word only when its result is sure to find room
	assign q_pop = !q_empty
		&& ((ocnt_q + irn_pkg::OCNT_W'(v_s1)) < irn_pkg::OCNT_W'(irn_pkg::OUT_DEPTH));
	assign we = q_pop && !q_data.is_read;
	assign re = q_pop && q_data.is_read && q_data.in_src;

	assign res_pix    = inside_s1 ? rdata_q : '0;
	assign empty      = (ocnt_q == '0);
	assign do_pop     = pop && !empty;
	assign pixel_out  = opix_q[orptr_q];
	assign inside_res = oin_q[orptr_q];

	// frame store: one access per cycle, in word order
	always_ff @(posedge clk) begin
		if (we)
			mem[q_data.addr] <= q_data.pixel;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[q_data.addr];
	end

	// mark a read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= q_pop && q_data.is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			inside_s1 <= q_data.in_src;
	end

	// result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (v_s1)
				owptr_q <= owptr_q + 1'b1;
			if (do_pop)
				orptr_q <= orptr_q + 1'b1;
			if (v_s1 && !do_pop)
				ocnt_q <= ocnt_q + 1'b1;
			else if (do_pop && !v_s1)
				ocnt_q <= ocnt_q - 1'b1;
		end
	end

	// hold results
	always_ff @(posedge clk) begin
		if (v_s1) begin
			opix_q[owptr_q] <= res_pix;
			oin_q[owptr_q]  <= inside_s1;
		end
	end

endmodule

### hdl/image_rotate_nearest.sv
// Channel   Handshake           Data
// input     push / full         command, col, row, pixel_in
// result    empty / pop         pixel_out, inside_res
// config    cfg_write           cfg_index, cfg_data
//
// One word per cycle is accepted while full is low; the front pipe is four
// stages, the back part makes one frame store access per cycle, and results
// flow at one per cycle while the result queue is popped and has room.
// Reset clears the registers to identity rotation at full size; the frame store
// is not cleared. A full result queue stalls the back part, which fills the
// middle queue and finally raises full on the input.
module image_rotate_nearest (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          command,
	input  logic [irn_pkg::COORD_W-1:0]   col,
	input  logic [irn_pkg::COORD_W-1:0]   row,
	input  logic [irn_pkg::PIX_W-1:0]     pixel_in,
	output logic                          empty,
	input  logic                          pop,
	output logic [irn_pkg::PIX_W-1:0]     pixel_out,
	output logic                          inside_res,
	input  logic                          cfg_write,
	input  logic [irn_pkg::IDX_W-1:0]     cfg_index,
	input  logic [irn_pkg::CFG_W-1:0]     cfg_data
);

	logic signed [irn_pkg::TRIG_W-1:0] cos_q;
	logic signed [irn_pkg::TRIG_W-1:0] sin_q;
	logic [irn_pkg::DIM_W-1:0]         width_q;
	logic [irn_pkg::DIM_W-1:0]         height_q;
	irn_pkg::cfg_t                     cfg;

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	irn_pkg::entry_t q_wdata;
	irn_pkg::entry_t q_rdata;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= irn_pkg::TRIG_W'(16384);
			sin_q    <= '0;
			width_q  <= irn_pkg::DIM_W'(256);
			height_q <= irn_pkg::DIM_W'(256);
		end else if (cfg_write) begin
			unique case (irn_pkg::reg_idx_t'(cfg_index))
				irn_pkg::REG_COS:    cos_q    <= cfg_data;
				irn_pkg::REG_SIN:    sin_q    <= cfg_data;
				irn_pkg::REG_WIDTH:  width_q  <= cfg_data[irn_pkg::DIM_W-1:0];
				irn_pkg::REG_HEIGHT: height_q <= cfg_data[irn_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp sizes to the store
	always_comb begin
		cfg.cos_v = cos_q;
		cfg.sin_v = sin_q;
		cfg.w = (32'(width_q) > irn_pkg::MAX_WIDTH) ? irn_pkg::DIM_W'(irn_pkg::MAX_WIDTH)
			: width_q;
		cfg.h = (32'(height_q) > irn_pkg::MAX_HEIGHT) ? irn_pkg::DIM_W'(irn_pkg::MAX_HEIGHT)
			: height_q;
	end

	irn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.full     (full),
		.command  (command),
		.col      (col),
		.row      (row),
		.pixel_in (pixel_in),
		.q_push   (q_push),
		.q_full   (q_full),
		.q_data   (q_wdata)
	);

	irn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	irn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_pop      (q_pop),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.empty      (empty),
		.pop        (pop),
		.pixel_out  (pixel_out),
		.inside_res (inside_res)
	);

endmodule
